>>> sv/gsic_pkg.sv
// ----------------------------------------------------------------------------
// gsic_pkg
// Shared types and constants for the integer gas sensor compensation pipeline.
// ----------------------------------------------------------------------------
package gsic_pkg;

	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 104;
	localparam int OUT_USER_W = 1;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	// output field positions inside m_axis_tdata
	localparam int OUT_PRES_LSB = 16;
	localparam int OUT_HUM_LSB  = 48;
	localparam int HUM_W        = 17;
	localparam logic [HUM_W-1:0] HUM_MAX = 17'd100000;

	// pipeline layout
	localparam int DIV_STEPS  = 32;
	localparam int ST_DIV0    = 11;
	localparam int ST_DIV_GEN = 17;
	localparam int ST_POST    = ST_DIV0 + DIV_STEPS;
	localparam int NSTAGE     = ST_POST + 4;

	// unsigned 32-bit divide by 100: multiply then shift right by 37
	localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP    = 8'd0,
		REG_PRES_LO = 8'd1,
		REG_PRES_HI = 8'd2,
		REG_PRES_10 = 8'd3,
		REG_HUM     = 8'd4,
		REG_RSE     = 8'd5
	} cfg_reg_t;

	localparam logic [31:0] GAS_TAB_A [16] = '{
		32'd2147483647, 32'd2147483647, 32'd2147483647, 32'd2147483647,
		32'd2147483647, 32'd2126008810, 32'd2147483647, 32'd2130303777,
		32'd2147483647, 32'd2147483647, 32'd2143188679, 32'd2136746228,
		32'd2147483647, 32'd2126008810, 32'd2147483647, 32'd2147483647
	};

	localparam logic [31:0] GAS_TAB_B [16] = '{
		32'd4096000000, 32'd2048000000, 32'd1024000000, 32'd512000000,
		32'd255744255, 32'd127110228, 32'd64000000, 32'd32258064,
		32'd16016016, 32'd8000000, 32'd4000000, 32'd2000000,
		32'd1000000, 32'd500000, 32'd250000, 32'd125000
	};

	// one item as it travels down the pipeline
	typedef struct packed {
		logic [19:0]        adc_t;
		logic [19:0]        adc_p;
		logic [15:0]        adc_h;
		logic [9:0]         adc_g;
		logic [3:0]         rng;
		// temperature
		logic signed [34:0] tm2;
		logic signed [35:0] thh;
		logic signed [34:0] tv2;
		logic signed [36:0] tv3m;
		logic signed [31:0] tfine;
		logic signed [31:0] ts;
		// gas
		logic [41:0]        g1p;
		logic [57:0]        g3p;
		logic signed [27:0] g2;
		logic [49:0]        gnum;
		logic [26:0]        gden;
		logic               gzero;
		logic [26:0]        grem;
		logic [31:0]        gdq;
		logic [31:0]        gas;
		// pressure
		logic signed [31:0] a1;
		logic signed [31:0] qq;
		logic signed [31:0] pa5;
		logic signed [31:0] pa2;
		logic signed [31:0] a2x;
		logic signed [31:0] a1x;
		logic signed [31:0] a2f;
		logic signed [31:0] psv;
		logic signed [31:0] a1fp;
		logic signed [31:0] pc0;
		logic signed [31:0] a1f;
		logic signed [31:0] pc;
		logic [31:0]        prem;
		logic [31:0]        pdq;
		logic [31:0]        pdiv;
		logic               pqneg;
		logic               ppost;
		logic               pinv;
		logic signed [31:0] pcv;
		logic signed [31:0] s3s;
		logic signed [31:0] b2p;
		logic signed [31:0] s8;
		logic signed [31:0] s8s;
		logic signed [31:0] b1p;
		logic signed [31:0] b2;
		logic signed [31:0] s8c;
		logic signed [31:0] b1;
		logic signed [31:0] b3p;
		logic [31:0]        pres;
		// humidity
		logic signed [31:0] th3;
		logic signed [31:0] th4;
		logic signed [31:0] th5;
		logic signed [31:0] th7;
		logic [3:0]         hneg;
		logic [3:0][62:0]   hprod;
		logic signed [31:0] d3;
		logic signed [31:0] d4;
		logic signed [31:0] d5;
		logic signed [31:0] d7;
		logic signed [31:0] c1;
		logic signed [31:0] t5;
		logic signed [31:0] c4;
		logic signed [31:0] hs;
		logic signed [31:0] c2;
		logic signed [31:0] c3;
		logic signed [31:0] c5p;
		logic signed [31:0] c6p;
		logic signed [31:0] hm;
		logic [HUM_W-1:0]   hum;
	} item_t;

endpackage

>>> sv/gas_sensor_integer_compensation.sv
// ----------------------------------------------------------------------------
// gas_sensor_integer_compensation
// Integer compensation of temperature, pressure, humidity and gas resistance.
//
//   channel | dir | handshake               | payload
//   s_axis  | in  | s_axis_tvalid/tready    | raw readings, gas range in tuser
//   m_axis  | out | m_axis_tvalid/tready    | compensated values, flag in tuser
//   cfg     | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// one item per cycle while the output is not stalled
// depth is mostly the two 32-stage restoring dividers (one quotient bit
// per stage) for the pressure and gas quotients
// reset clears valid bits and calibration registers, no clearing pass
// a stalled output freezes the whole pipeline, s_axis_tready drops with it
// ----------------------------------------------------------------------------
module gas_sensor_integer_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// raw_temp, raw_pres, raw_hum, raw_gas, zero fill
	input  logic [gsic_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// gas_range_sel
	input  logic [gsic_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// temp_centi, pressure_pa, humidity_milli, gas_ohms, zero fill
	output logic [gsic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// pressure_invalid
	output logic [gsic_pkg::OUT_USER_W-1:0]  m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gsic_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gsic_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gsic_pkg::*;

	logic [39:0] temp_q;
	logic [55:0] pres_lo_q;
	logic [63:0] pres_hi_q;
	logic [7:0]  pres_ten_q;
	logic [63:0] hum_q;
	logic [3:0]  rse_q;

	logic [15:0]        t1;
	logic signed [15:0] t2;
	logic signed [11:0] t3x;
	logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
	logic signed [31:0] h1, h2, h3, h4, h5, h6, h7;
	logic signed [11:0] gas_fac_s;
	logic [10:0]        gas_fac;

	item_t       c [1:NSTAGE];
	item_t       pipe_s [1:NSTAGE];
	logic [NSTAGE:1] vld_s;
	logic        en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q     <= '0;
			pres_lo_q  <= '0;
			pres_hi_q  <= '0;
			pres_ten_q <= '0;
			hum_q      <= '0;
			rse_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMP:    temp_q     <= cfg_data[39:0];
				REG_PRES_LO: pres_lo_q  <= cfg_data[55:0];
				REG_PRES_HI: pres_hi_q  <= cfg_data;
				REG_PRES_10: pres_ten_q <= cfg_data[7:0];
				REG_HUM:     hum_q      <= cfg_data;
				REG_RSE:     rse_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// calibration fields, widened to 32 bits where the math wraps at 32
	assign t1  = temp_q[15:0];
	assign t2  = temp_q[31:16];
	assign t3x = {temp_q[39:32], 4'd0};
	assign p1  = $signed({16'd0, pres_lo_q[15:0]});
	assign p2  = $signed({{16{pres_lo_q[31]}}, pres_lo_q[31:16]});
	assign p3  = $signed({{24{pres_lo_q[39]}}, pres_lo_q[39:32]});
	assign p4  = $signed({{16{pres_lo_q[55]}}, pres_lo_q[55:40]});
	assign p5  = $signed({{16{pres_hi_q[15]}}, pres_hi_q[15:0]});
	assign p6  = $signed({{24{pres_hi_q[23]}}, pres_hi_q[23:16]});
	assign p7  = $signed({{24{pres_hi_q[31]}}, pres_hi_q[31:24]});
	assign p8  = $signed({{16{pres_hi_q[47]}}, pres_hi_q[47:32]});
	assign p9  = $signed({{16{pres_hi_q[63]}}, pres_hi_q[63:48]});
	assign p10 = $signed({24'd0, pres_ten_q});
	assign h1  = $signed({20'd0, hum_q[11:0]});
	assign h2  = $signed({20'd0, hum_q[23:12]});
	assign h3  = $signed({{24{hum_q[31]}}, hum_q[31:24]});
	assign h4  = $signed({{24{hum_q[39]}}, hum_q[39:32]});
	assign h5  = $signed({{24{hum_q[47]}}, hum_q[47:40]});
	assign h6  = $signed({24'd0, hum_q[55:48]});
	assign h7  = $signed({{24{hum_q[63]}}, hum_q[63:56]});
	assign gas_fac_s = 12'sd1340 + 12'sd5 * $signed({{8{rse_q[3]}}, rse_q});
	assign gas_fac   = gas_fac_s[10:0];

	// signed truncating divide by 100, split over two stages
	function automatic logic [63:0] div100_mul(input logic signed [31:0] x);
		logic [31:0] mag;
		logic [62:0] p;
		mag = x[31] ? 32'(-x) : 32'(x);
		p   = mag * DIV100_MAGIC;
		return {x[31], p};
	endfunction

	function automatic logic signed [31:0] div100_fin(input logic neg, input logic [62:0] p);
		logic [31:0] m;
		m = {6'd0, p[62:37]};
		return neg ? -$signed(m) : $signed(m);
	endfunction

	// one restoring step of both dividers
	function automatic item_t div_step(input item_t x);
		item_t       r;
		logic [32:0] pt;
		logic [32:0] pd;
		logic [27:0] gt;
		logic [27:0] gd;
		r  = x;
		pt = {x.prem, x.pdq[31]};
		pd = pt - {1'b0, x.pdiv};
		if (pt >= {1'b0, x.pdiv}) begin
			r.prem = pd[31:0];
			r.pdq  = {x.pdq[30:0], 1'b1};
		end else begin
			r.prem = pt[31:0];
			r.pdq  = {x.pdq[30:0], 1'b0};
		end
		gt = {x.grem, x.gdq[31]};
		gd = gt - {1'b0, x.gden};
		if (gt >= {1'b0, x.gden}) begin
			r.grem = gd[26:0];
			r.gdq  = {x.gdq[30:0], 1'b1};
		end else begin
			r.grem = gt[26:0];
			r.gdq  = {x.gdq[30:0], 1'b0};
		end
		return r;
	endfunction

	// s1: temperature products, gas table product
	always_comb begin
		logic signed [18:0] v1;
		logic signed [18:0] vh;
		c[1]       = '0;
		c[1].adc_t = s_axis_tdata[19:0];
		c[1].adc_p = s_axis_tdata[39:20];
		c[1].adc_h = s_axis_tdata[55:40];
		c[1].adc_g = s_axis_tdata[65:56];
		c[1].rng   = s_axis_tuser;
		v1 = $signed({2'b00, s_axis_tdata[19:3]}) - $signed({2'b00, t1, 1'b0});
		vh = v1 >>> 1;
		c[1].tm2 = v1 * t2;
		c[1].thh = vh * vh;
		c[1].g1p = gas_fac * GAS_TAB_A[s_axis_tuser];
	end

	// s2
	always_comb begin
		logic signed [35:0] v3a;
		logic signed [24:0] v3n;
		logic [25:0]        g1;
		c[2]      = pipe_s[1];
		c[2].tv2  = pipe_s[1].tm2 >>> 11;
		v3a       = pipe_s[1].thh >>> 12;
		v3n       = v3a[24:0];
		c[2].tv3m = v3n * t3x;
		g1        = pipe_s[1].g1p[41:16];
		c[2].g3p  = GAS_TAB_B[pipe_s[1].rng] * g1;
		c[2].g2   = $signed({3'b000, pipe_s[1].adc_g, 15'd0}) - 28'sd16777216
			+ $signed({2'b00, g1});
	end

	// s3: fine temperature, gas dividend
	always_comb begin
		logic signed [39:0] tsum;
		c[3]       = pipe_s[2];
		tsum       = pipe_s[2].tv2 + (pipe_s[2].tv3m >>> 14);
		c[3].tfine = tsum[31:0];
		c[3].gzero = pipe_s[2].g2[27] || (pipe_s[2].g2 == '0);
		c[3].gden  = pipe_s[2].g2[26:0];
		c[3].gnum  = {1'b0, pipe_s[2].g3p[57:9]} + {24'd0, pipe_s[2].g2[26:1]};
	end

	// s4
	always_comb begin
		c[4]    = pipe_s[3];
		c[4].ts = (pipe_s[3].tfine * 32'sd5 + 32'sd128) >>> 8;
		c[4].a1 = (pipe_s[3].tfine >>> 1) - 32'sd64000;
	end

	// s5
	always_comb begin
		logic signed [31:0] q;
		c[5]     = pipe_s[4];
		q        = pipe_s[4].a1 >>> 2;
		c[5].qq  = q * q;
		c[5].pa5 = pipe_s[4].a1 * p5;
		c[5].pa2 = p2 * pipe_s[4].a1;
		c[5].th3 = pipe_s[4].ts * h3;
		c[5].th4 = pipe_s[4].ts * h4;
		c[5].th5 = pipe_s[4].ts * h5;
		c[5].th7 = pipe_s[4].ts * h7;
	end

	// s6
	always_comb begin
		logic [63:0] r3, r4, r5, r7;
		c[6]     = pipe_s[5];
		c[6].a2x = (pipe_s[5].qq >>> 11) * p6;
		c[6].a1x = (pipe_s[5].qq >>> 13) * (p3 <<< 5);
		r3 = div100_mul(pipe_s[5].th3);
		r4 = div100_mul(pipe_s[5].th4);
		r5 = div100_mul(pipe_s[5].th5);
		r7 = div100_mul(pipe_s[5].th7);
		c[6].hneg     = {r7[63], r5[63], r4[63], r3[63]};
		c[6].hprod[0] = r3[62:0];
		c[6].hprod[1] = r4[62:0];
		c[6].hprod[2] = r5[62:0];
		c[6].hprod[3] = r7[62:0];
	end

	// s7
	always_comb begin
		logic signed [31:0] a2;
		logic signed [31:0] a1y;
		c[7]     = pipe_s[6];
		a2       = (pipe_s[6].a2x >>> 2) + (pipe_s[6].pa5 <<< 1);
		c[7].a2f = (a2 >>> 2) + (p4 <<< 16);
		a1y      = (pipe_s[6].a1x >>> 3) + (pipe_s[6].pa2 >>> 1);
		c[7].psv = 32'sd32768 + (a1y >>> 18);
		c[7].d3  = div100_fin(pipe_s[6].hneg[0], pipe_s[6].hprod[0]);
		c[7].d4  = div100_fin(pipe_s[6].hneg[1], pipe_s[6].hprod[1]);
		c[7].d5  = div100_fin(pipe_s[6].hneg[2], pipe_s[6].hprod[2]);
		c[7].d7  = div100_fin(pipe_s[6].hneg[3], pipe_s[6].hprod[3]);
	end

	// s8
	always_comb begin
		c[8]      = pipe_s[7];
		c[8].a1fp = pipe_s[7].psv * p1;
		c[8].pc0  = 32'sd1048576 - $signed({12'd0, pipe_s[7].adc_p})
			- (pipe_s[7].a2f >>> 12);
		c[8].c1   = ($signed({16'd0, pipe_s[7].adc_h}) - h1 * 32'sd16)
			- (pipe_s[7].d3 >>> 1);
		c[8].t5   = pipe_s[7].ts * pipe_s[7].d5;
		c[8].c4   = ((h6 <<< 7) + pipe_s[7].d7) >>> 4;
	end

	// s9
	always_comb begin
		logic [63:0] r;
		c[9]          = pipe_s[8];
		c[9].a1f      = pipe_s[8].a1fp >>> 15;
		c[9].pc       = pipe_s[8].pc0 * 32'sd3125;
		r             = div100_mul(pipe_s[8].t5 >>> 6);
		c[9].hneg[0]  = r[63];
		c[9].hprod[0] = r[62:0];
	end

	// s10: divider set-up
	always_comb begin
		logic               ge;
		logic signed [31:0] dvd;
		ge    = pipe_s[9].pc >= 32'sh40000000;
		dvd   = ge ? pipe_s[9].pc : (pipe_s[9].pc <<< 1);
		c[10] = pipe_s[9];
		c[10].ppost = ge;
		c[10].pqneg = dvd[31] ^ pipe_s[9].a1f[31];
		c[10].pdq   = dvd[31] ? 32'(-dvd) : 32'(dvd);
		c[10].pdiv  = pipe_s[9].a1f[31] ? 32'(-pipe_s[9].a1f) : 32'(pipe_s[9].a1f);
		c[10].pinv  = pipe_s[9].a1f == '0;
		c[10].prem  = '0;
		c[10].grem  = {9'd0, pipe_s[9].gnum[49:32]};
		c[10].gdq   = pipe_s[9].gnum[31:0];
		c[10].hs    = pipe_s[9].d4 + div100_fin(pipe_s[9].hneg[0], pipe_s[9].hprod[0])
			+ 32'sd16384;
	end

	// s11..s16: divider steps with the humidity tail alongside
	always_comb begin
		c[11]    = div_step(pipe_s[10]);
		c[11].c2 = (h2 * pipe_s[10].hs) >>> 10;
	end

	always_comb begin
		c[12]    = div_step(pipe_s[11]);
		c[12].c3 = pipe_s[11].c1 * pipe_s[11].c2;
	end

	always_comb begin
		logic signed [31:0] c3s;
		c[13]     = div_step(pipe_s[12]);
		c3s       = pipe_s[12].c3 >>> 14;
		c[13].c5p = c3s * c3s;
	end

	always_comb begin
		c[14]     = div_step(pipe_s[13]);
		c[14].c6p = pipe_s[13].c4 * (pipe_s[13].c5p >>> 10);
	end

	always_comb begin
		c[15]    = div_step(pipe_s[14]);
		c[15].hm = ((pipe_s[14].c3 + (pipe_s[14].c6p >>> 1)) >>> 10) * 32'sd1000;
	end

	always_comb begin
		logic signed [31:0] hv;
		c[16] = div_step(pipe_s[15]);
		hv    = pipe_s[15].hm >>> 12;
		if (hv > $signed({15'd0, HUM_MAX}))
			c[16].hum = HUM_MAX;
		else if (hv < 0)
			c[16].hum = '0;
		else
			c[16].hum = hv[HUM_W-1:0];
	end

	for (genvar k = ST_DIV_GEN; k < ST_POST; k++) begin : g_div
		always_comb begin
			c[k] = div_step(pipe_s[k-1]);
		end
	end

	// quotient sign and post shift
	always_comb begin
		logic signed [31:0] pq;
		c[ST_POST]     = pipe_s[ST_POST-1];
		pq             = pipe_s[ST_POST-1].pqneg ? -$signed(pipe_s[ST_POST-1].pdq)
			: $signed(pipe_s[ST_POST-1].pdq);
		c[ST_POST].pcv = pipe_s[ST_POST-1].ppost ? (pq <<< 1) : pq;
		c[ST_POST].gas = pipe_s[ST_POST-1].gzero ? '0 : pipe_s[ST_POST-1].gdq;
	end

	always_comb begin
		logic signed [31:0] s3;
		c[ST_POST+1]     = pipe_s[ST_POST];
		s3               = pipe_s[ST_POST].pcv >>> 3;
		c[ST_POST+1].s3s = s3 * s3;
		c[ST_POST+1].b2p = (pipe_s[ST_POST].pcv >>> 2) * p8;
		c[ST_POST+1].s8  = pipe_s[ST_POST].pcv >>> 8;
		c[ST_POST+1].s8s = (pipe_s[ST_POST].pcv >>> 8) * (pipe_s[ST_POST].pcv >>> 8);
	end

	always_comb begin
		c[ST_POST+2]     = pipe_s[ST_POST+1];
		c[ST_POST+2].b1p = p9 * (pipe_s[ST_POST+1].s3s >>> 13);
		c[ST_POST+2].b2  = pipe_s[ST_POST+1].b2p >>> 13;
		c[ST_POST+2].s8c = pipe_s[ST_POST+1].s8s * pipe_s[ST_POST+1].s8;
	end

	always_comb begin
		c[ST_POST+3]     = pipe_s[ST_POST+2];
		c[ST_POST+3].b1  = pipe_s[ST_POST+2].b1p >>> 12;
		c[ST_POST+3].b3p = pipe_s[ST_POST+2].s8c * p10;
	end

	always_comb begin
		logic signed [31:0] corr;
		c[NSTAGE] = pipe_s[NSTAGE-1];
		corr = (pipe_s[NSTAGE-1].b1 + pipe_s[NSTAGE-1].b2 + (pipe_s[NSTAGE-1].b3p >>> 17)
			+ (p7 <<< 7)) >>> 4;
		c[NSTAGE].pres = pipe_s[NSTAGE-1].pinv ? '0 : 32'(pipe_s[NSTAGE-1].pcv + corr);
	end

	// the whole pipeline holds while the last item waits
	assign en            = !vld_s[NSTAGE] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTAGE-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= NSTAGE; k++) begin
				pipe_s[k] <= c[k];
			end
		end
	end

	assign m_axis_tvalid = vld_s[NSTAGE];
	assign m_axis_tdata  = {7'd0, pipe_s[NSTAGE].gas, pipe_s[NSTAGE].hum,
		pipe_s[NSTAGE].pres, pipe_s[NSTAGE].ts[15:0]};
	assign m_axis_tuser  = pipe_s[NSTAGE].pinv;

endmodule

>>> sv/gsic_checker.sv
// ----------------------------------------------------------------------------
// gsic_checker
// Port-level checks on the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module gsic_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [gsic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [gsic_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
	import gsic_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	// a valid result held by a blocked output means no new item is taken
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("item accepted while output blocked");

	a_pinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[OUT_PRES_LSB +: 32] == '0)
		else $error("invalid pressure not forced to zero");

	a_hum_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_HUM_LSB +: HUM_W] <= HUM_MAX)
		else $error("humidity above full scale");

endmodule

bind gas_sensor_integer_compensation gsic_checker u_gsic_checker (.*);

>>> test/gas_sensor_integer_compensation_tb.sv
// ----------------------------------------------------------------------------
// gas_sensor_integer_compensation_tb
// Drives raw reading sets into the compensation pipeline under several
// calibration settings and flow-control patterns, and checks every result
// against a cycle-free integer model kept in this bench.
// ----------------------------------------------------------------------------
module gas_sensor_integer_compensation_tb;
	import gsic_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd6;

	// typical calibration set
	localparam logic [39:0] CAL_TEMP    = {8'd3, 16'd26000, 16'd26500};
	localparam logic [55:0] CAL_PRES_LO = {16'd5000, 8'd88, 16'hD7C4, 16'd36000};
	localparam logic [63:0] CAL_PRES_HI = {16'hF448, 16'hFED4, 8'd30, 8'd30, 16'hFF9C};
	localparam logic [7:0]  CAL_P10     = 8'd30;
	localparam logic [63:0] CAL_HUM     = {8'h9C, 8'd120, 8'd20, 8'd45, 8'd0, 12'd1000, 12'd700};

	typedef struct packed {
		logic [19:0] temp;
		logic [19:0] pres;
		logic [15:0] hum;
		logic [9:0]  gas;
		logic [3:0]  rng;
	} reading_t;

	typedef struct packed {
		logic [15:0] temp;
		logic [31:0] pres;
		logic        pinv;
		logic [16:0] hum;
		logic [31:0] gas;
	} comp_t;

	typedef struct packed {
		reading_t rd;
		logic     at_reset;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// calibration as the block should hold it
	logic [39:0] cal_temp = '0;
	logic [55:0] cal_pres_lo = '0;
	logic [63:0] cal_pres_hi = '0;
	logic [7:0]  cal_p10 = '0;
	logic [63:0] cal_hum = '0;
	logic [3:0]  cal_rse = '0;

	comp_t pending_q[$];
	int errors = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	gas_sensor_integer_compensation u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// truncating signed divide, most negative by -1 wraps
	function automatic int sdiv(int a, int b);
		longint q;
		q = longint'(a) / longint'(b);
		return int'(q);
	endfunction

	function automatic comp_t compensate(reading_t r);
		longint t1, t2, t3, v1, v2, hh, v3;
		int tfine, ts;
		int p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
		int a1, q, a2, pc, s3, b1, b2, s8, b3;
		int h1, h2, h3, h4, h5, h6, h7, c1, c2, c3, c4, c3s, c5, c6, hm;
		longint rse, g1, g2, g3, gq;
		comp_t o;
		// temperature, 64-bit
		t1 = longint'(cal_temp[15:0]);
		t2 = longint'($signed(cal_temp[31:16]));
		t3 = longint'($signed(cal_temp[39:32]));
		v1 = longint'(r.temp >> 3) - (t1 <<< 1);
		v2 = (v1 * t2) >>> 11;
		hh = v1 >>> 1;
		v3 = (hh * hh) >>> 12;
		v3 = (v3 * (t3 <<< 4)) >>> 14;
		tfine = int'(v2 + v3);
		ts = (tfine * 5 + 128) >>> 8;
		// pressure, 32-bit wrapping
		p1 = int'(cal_pres_lo[15:0]);
		p2 = int'($signed(cal_pres_lo[31:16]));
		p3 = int'($signed(cal_pres_lo[39:32]));
		p4 = int'($signed(cal_pres_lo[55:40]));
		p5 = int'($signed(cal_pres_hi[15:0]));
		p6 = int'($signed(cal_pres_hi[23:16]));
		p7 = int'($signed(cal_pres_hi[31:24]));
		p8 = int'($signed(cal_pres_hi[47:32]));
		p9 = int'($signed(cal_pres_hi[63:48]));
		p10 = int'(cal_p10);
		a1 = (tfine >>> 1) - 64000;
		q = a1 >>> 2;
		a2 = (((q * q) >>> 11) * p6) >>> 2;
		a2 = a2 + ((a1 * p5) <<< 1);
		a2 = (a2 >>> 2) + (p4 <<< 16);
		a1 = ((((q * q) >>> 13) * (p3 <<< 5)) >>> 3) + ((p2 * a1) >>> 1);
		a1 = a1 >>> 18;
		a1 = ((32768 + a1) * p1) >>> 15;
		pc = 1048576 - int'(r.pres);
		pc = (pc - (a2 >>> 12)) * 3125;
		if (a1 == 0) begin
			pc = 0;
			o.pinv = 1'b1;
		end else begin
			o.pinv = 1'b0;
			if (pc >= 1073741824)
				pc = sdiv(pc, a1) <<< 1;
			else
				pc = sdiv(pc <<< 1, a1);
			s3 = pc >>> 3;
			b1 = (p9 * ((s3 * s3) >>> 13)) >>> 12;
			b2 = ((pc >>> 2) * p8) >>> 13;
			s8 = pc >>> 8;
			b3 = (s8 * s8 * s8 * p10) >>> 17;
			pc = pc + ((b1 + b2 + b3 + (p7 <<< 7)) >>> 4);
		end
		// humidity, 32-bit wrapping
		h1 = int'(cal_hum[11:0]);
		h2 = int'(cal_hum[23:12]);
		h3 = int'($signed(cal_hum[31:24]));
		h4 = int'($signed(cal_hum[39:32]));
		h5 = int'($signed(cal_hum[47:40]));
		h6 = int'(cal_hum[55:48]);
		h7 = int'($signed(cal_hum[63:56]));
		c1 = (int'(r.hum) - h1 * 16) - (sdiv(ts * h3, 100) >>> 1);
		c2 = (h2 * (sdiv(ts * h4, 100) + sdiv((ts * sdiv(ts * h5, 100)) >>> 6, 100)
			+ 16384)) >>> 10;
		c3 = c1 * c2;
		c4 = ((h6 <<< 7) + sdiv(ts * h7, 100)) >>> 4;
		c3s = c3 >>> 14;
		c5 = (c3s * c3s) >>> 10;
		c6 = (c4 * c5) >>> 1;
		hm = (((c3 + c6) >>> 10) * 1000) >>> 12;
		if (hm > 100000)
			hm = 100000;
		else if (hm < 0)
			hm = 0;
		// gas, 64-bit
		rse = longint'($signed(cal_rse));
		g1 = ((1340 + 5 * rse) * longint'(GAS_TAB_A[r.rng])) / 65536;
		g2 = longint'(r.gas) * 32768 - 16777216 + g1;
		g3 = (longint'(GAS_TAB_B[r.rng]) * g1) / 512;
		gq = (g2 > 0) ? (g3 + g2 / 2) / g2 : 0;
		o.temp = ts[15:0];
		o.pres = pc;
		o.hum = hm[16:0];
		o.gas = gq[31:0];
		return o;
	endfunction

	task automatic mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEMP:    cal_temp = v[39:0];
			REG_PRES_LO: cal_pres_lo = v[55:0];
			REG_PRES_HI: cal_pres_hi = v;
			REG_PRES_10: cal_p10 = v[7:0];
			REG_HUM:     cal_hum = v;
			REG_RSE:     cal_rse = v[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_cal(logic [39:0] t, logic [55:0] pl, logic [63:0] ph,
		logic [7:0] p10, logic [63:0] hc, logic [3:0] rse);
		write_reg(REG_TEMP, 64'(t));
		write_reg(REG_PRES_LO, 64'(pl));
		write_reg(REG_PRES_HI, ph);
		write_reg(REG_PRES_10, 64'(p10));
		write_reg(REG_HUM, hc);
		write_reg(REG_RSE, 64'(rse));
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one item; valid stays high into the next item unless a gap is drawn
	task automatic send_reading(reading_t r, logic at_reset);
		comp_t e;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {6'b0, r.gas, r.hum, r.pres, r.temp};
		s_axis_tuser <= r.rng;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		e = compensate(r);
		if (at_reset) begin
			// zero calibration: no fine temperature, zero divisor, no humidity
			e.temp = '0;
			e.pres = '0;
			e.pinv = 1'b1;
			e.hum = '0;
		end
		pending_q.push_back(e);
	endtask

	function automatic logic [19:0] pick_field(int w);
		logic [19:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = 20'((64'd1 << w) - 1);
			default: v = 20'($urandom_range((1 << w) - 1));
		endcase
		return v;
	endfunction

	// receiver side
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		comp_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				mismatch("unexpected item", m_axis_tdata[47:16], 32'd0);
			end else begin
				e = pending_q.pop_front();
				if (m_axis_tdata[15:0] !== e.temp)
					mismatch("temp_centi", 32'(m_axis_tdata[15:0]), 32'(e.temp));
				if (m_axis_tdata[47:16] !== e.pres)
					mismatch("pressure_pa", m_axis_tdata[47:16], e.pres);
				if (m_axis_tuser[0] !== e.pinv)
					mismatch("pressure_invalid", 32'(m_axis_tuser[0]), 32'(e.pinv));
				if (m_axis_tdata[64:48] !== e.hum)
					mismatch("humidity_milli", 32'(m_axis_tdata[64:48]), 32'(e.hum));
				if (m_axis_tdata[96:65] !== e.gas)
					mismatch("gas_ohms", m_axis_tdata[96:65], e.gas);
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	row_t dir_rows [16] = '{
		// after reset, zero calibration
		'{'{20'h00000, 20'h00000, 16'h0000, 10'h000, 4'd0}, 1'b1},
		'{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 10'h3FF, 4'd15}, 1'b1},
		'{'{20'hAAAAA, 20'h55555, 16'hAAAA, 10'h155, 4'd5}, 1'b1},
		'{'{20'h55555, 20'hAAAAA, 16'h5555, 10'h2AA, 4'd10}, 1'b1},
		'{'{20'h7A120, 20'h5B8D8, 16'h6590, 10'h200, 4'd4}, 1'b1},
		'{'{20'hFFFFF, 20'h00000, 16'hFFFF, 10'h000, 4'd7}, 1'b1},
		// typical calibration
		'{'{20'h7A120, 20'h5B8D8, 16'h6590, 10'h200, 4'd0}, 1'b0},
		'{'{20'h00000, 20'h00000, 16'h0000, 10'h000, 4'd1}, 1'b0},
		'{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 10'h3FF, 4'd15}, 1'b0},
		'{'{20'h80000, 20'h80000, 16'h8000, 10'h200, 4'd3}, 1'b0},
		'{'{20'h7FFFF, 20'h00001, 16'h7FFF, 10'h1FF, 4'd8}, 1'b0},
		'{'{20'h6B000, 20'h4E200, 16'h5000, 10'h0F0, 4'd11}, 1'b0},
		'{'{20'h8C000, 20'h64000, 16'h7800, 10'h300, 4'd13}, 1'b0},
		'{'{20'h00000, 20'hFFFFF, 16'h0000, 10'h3FF, 4'd6}, 1'b0},
		'{'{20'hFFFFF, 20'h00000, 16'hFFFF, 10'h001, 4'd12}, 1'b0},
		'{'{20'h74000, 20'h58000, 16'h6000, 10'h180, 4'd14}, 1'b0}
	};

	initial begin
		reading_t r;
		logic calibrated;
		calibrated = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (!dir_rows[i].at_reset && !calibrated) begin
				s_axis_tvalid <= 1'b0;
				wait_idle();
				load_cal(CAL_TEMP, CAL_PRES_LO, CAL_PRES_HI, CAL_P10, CAL_HUM, 4'd0);
				calibrated = 1'b1;
			end
			send_reading(dir_rows[i].rd, dir_rows[i].at_reset);
		end

		for (int ph = 0; ph < 8; ph++) begin
			s_axis_tvalid <= 1'b0;
			wait_idle();
			case (ph)
				0: load_cal(CAL_TEMP, CAL_PRES_LO, CAL_PRES_HI, CAL_P10, CAL_HUM, 4'd0);
				1: load_cal('1, '1, '1, '1, '1, '1);
				3: load_cal('0, '0, '0, '0, '0, 4'h8);
				4: load_cal(CAL_TEMP, CAL_PRES_LO, CAL_PRES_HI, 8'hFF, CAL_HUM,
					4'($urandom_range(15)));
				6: load_cal(CAL_TEMP, CAL_PRES_LO, CAL_PRES_HI, 8'd0, CAL_HUM, 4'd7);
				default: load_cal(40'({$urandom, $urandom}), 56'({$urandom, $urandom}),
					{$urandom, $urandom}, 8'($urandom), {$urandom, $urandom},
					4'($urandom));
			endcase
			// write to an unused index must not disturb the calibration
			if (ph == 2)
				write_reg(REG_SPARE, {$urandom, $urandom});
			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
				default: begin src_idle_pct = 24; sink_stall_pct = 24; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long receiver hold-off so the pipeline fills and backs up
				if (ph == 0 && n == 60)
					hold_left = 300;
				r.temp = pick_field(20);
				r.pres = pick_field(20);
				r.hum = 16'(pick_field(16));
				r.gas = 10'(pick_field(10));
				r.rng = 4'($urandom_range(15));
				send_reading(r, 1'b0);
			end
		end
		s_axis_tvalid <= 1'b0;
		sink_stall_pct = 0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
sv/gsic_pkg.sv
sv/gas_sensor_integer_compensation.sv
sv/gsic_checker.sv
test/gas_sensor_integer_compensation_tb.sv
